// ----- hw/rtl/dd_pkg.sv -----
// ----------------------------------------------------------------------------
// dd_pkg: shared widths and calendar helpers
// Field widths of the date ports and the day-of-year lookup used by the
// date difference block.
// ----------------------------------------------------------------------------
package dd_pkg;

    localparam int YEAR_W       = 12;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int DIFF_W       = 22;
    localparam int DOY_W        = 9;
    localparam int DELTA_W      = 11;
    localparam int MAX_YEAR_DEF = 4095;

    // Days in the whole months before the given month; out-of-range months
    // above twelve count the whole year, month zero counts nothing.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] d;
        begin
            case (month)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                default: d = 9'd365;
            endcase
            return d;
        end
    endfunction

    function automatic logic [DOY_W-1:0] day_of_year(
        input logic [MONTH_W-1:0] month,
        input logic [DAY_W-1:0]   day,
        input logic               leap
    );
        logic [DOY_W-1:0] d;
        begin
            d = days_before(month) + DOY_W'(day);
            if (leap && (month > 4'd2))
            begin
                d = d + 9'd1;
            end
            return d;
        end
    endfunction

endpackage

// ----- hw/rtl/dd_year_ctr.sv -----
// ----------------------------------------------------------------------------
// dd_year_ctr: year counter with leap flag
// Counts years upward from zero and keeps residues mod 4, 100 and 400 so
// the leap flag of the current year needs no division.
// ----------------------------------------------------------------------------
module dd_year_ctr #(
    parameter int MAX_YEAR = dd_pkg::MAX_YEAR_DEF,
    localparam int YW      = (MAX_YEAR < 1) ? 1 : $clog2(MAX_YEAR + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          advance,
    output logic [YW-1:0] year,
    output logic          leap
);

    logic [YW-1:0] year_reg;
    logic [1:0]    mod4_reg;
    logic [6:0]    mod100_reg;
    logic [8:0]    mod400_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= '0;
            mod4_reg   <= '0;
            mod100_reg <= '0;
            mod400_reg <= '0;
        end
        else if (clear)
        begin
            year_reg   <= '0;
            mod4_reg   <= '0;
            mod100_reg <= '0;
            mod400_reg <= '0;
        end
        else if (advance)
        begin
            year_reg   <= year_reg + 1'b1;
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == 7'd99)  ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end
    end

    assign year = year_reg;
    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

endmodule

// ----- hw/rtl/date_difference_days.sv -----
// ----------------------------------------------------------------------------
// date_difference_days: signed day count between two Gregorian dates
// Returns the days from date B to date A by sweeping years from zero.
// ----------------------------------------------------------------------------
// Sequence: after the accepted request the sweep runs over the years from zero
//   to max(year_a, year_b), one year per cycle, then adds A's day of year and subtracts B's.
// Throughput: one request at a time; busy stays high until done is shown,
//   and a new request may be taken in the cycle that shows done.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns to idle with done low.
module date_difference_days #(
    parameter int MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dd_pkg::YEAR_W-1:0]        year_a,
    input  logic [dd_pkg::MONTH_W-1:0]       month_a,
    input  logic [dd_pkg::DAY_W-1:0]         day_a,
    input  logic [dd_pkg::YEAR_W-1:0]        year_b,
    input  logic [dd_pkg::MONTH_W-1:0]       month_b,
    input  logic [dd_pkg::DAY_W-1:0]         day_b,
    output logic                             done,
    output logic signed [dd_pkg::DIFF_W-1:0] day_difference
);

    localparam int YW = (MAX_YEAR < 1) ? 1 : $clog2(MAX_YEAR + 1);
    localparam int DW = dd_pkg::DIFF_W;
    localparam int EW = dd_pkg::DELTA_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ADD_A,
        ST_ADD_B
    } state_t;

    state_t                        state_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic signed [DW-1:0]          diff_reg;
    logic signed [DW-1:0]          acc_reg;
    logic [YW-1:0]                 ya_reg;
    logic [YW-1:0]                 yb_reg;
    logic [YW-1:0]                 hi_reg;
    logic [dd_pkg::MONTH_W-1:0]    ma_reg;
    logic [dd_pkg::MONTH_W-1:0]    mb_reg;
    logic [dd_pkg::DAY_W-1:0]      da_reg;
    logic [dd_pkg::DAY_W-1:0]      db_reg;
    logic                          leap_a_reg;
    logic                          leap_b_reg;

    logic                          accept;
    logic [31:0]                   ya_ext;
    logic [31:0]                   yb_ext;
    logic [31:0]                   ya_sat;
    logic [31:0]                   yb_sat;
    logic [YW-1:0]                 ya_in;
    logic [YW-1:0]                 yb_in;
    logic [YW-1:0]                 cur_year;
    logic                          cur_leap;
    logic                          ctr_advance;
    logic [dd_pkg::DOY_W-1:0]      year_len;
    logic [dd_pkg::DOY_W-1:0]      doy_a;
    logic [dd_pkg::DOY_W-1:0]      doy_b;
    logic signed [EW-1:0]          delta;
    logic signed [DW-1:0]          acc_sum;

    assign accept = start && !busy_reg;

    // Clamp years above the supported range
    assign ya_ext = 32'(year_a);
    assign yb_ext = 32'(year_b);
    assign ya_sat = (ya_ext > 32'(MAX_YEAR)) ? 32'(MAX_YEAR) : ya_ext;
    assign yb_sat = (yb_ext > 32'(MAX_YEAR)) ? 32'(MAX_YEAR) : yb_ext;
    assign ya_in  = ya_sat[YW-1:0];
    assign yb_in  = yb_sat[YW-1:0];

    assign ctr_advance = (state_reg == ST_SWEEP) && (cur_year != hi_reg);

    dd_year_ctr #(
        .MAX_YEAR (MAX_YEAR)
    ) u_year_ctr (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept),
        .advance (ctr_advance),
        .year    (cur_year),
        .leap    (cur_leap)
    );

    assign year_len = cur_leap ? 9'd366 : 9'd365;
    assign doy_a    = dd_pkg::day_of_year(ma_reg, da_reg, leap_a_reg);
    assign doy_b    = dd_pkg::day_of_year(mb_reg, db_reg, leap_b_reg);

    // Operand select for the shared accumulator adder
    always_comb
    begin
        delta = '0;
        case (state_reg)
            ST_SWEEP:
            begin
                if ((cur_year < ya_reg) && !(cur_year < yb_reg))
                begin
                    delta = $signed({2'b00, year_len});
                end
                else if (!(cur_year < ya_reg) && (cur_year < yb_reg))
                begin
                    delta = -$signed({2'b00, year_len});
                end
            end
            ST_ADD_A: delta = $signed({2'b00, doy_a});
            ST_ADD_B: delta = -$signed({2'b00, doy_b});
            default:  delta = '0;
        endcase
    end

    assign acc_sum = acc_reg + $signed({{(DW-EW){delta[EW-1]}}, delta});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            diff_reg   <= '0;
            acc_reg    <= '0;
            ya_reg     <= '0;
            yb_reg     <= '0;
            hi_reg     <= '0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            da_reg     <= '0;
            db_reg     <= '0;
            leap_a_reg <= 1'b0;
            leap_b_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ya_reg    <= ya_in;
                        yb_reg    <= yb_in;
                        hi_reg    <= (ya_in > yb_in) ? ya_in : yb_in;
                        ma_reg    <= month_a;
                        mb_reg    <= month_b;
                        da_reg    <= day_a;
                        db_reg    <= day_b;
                        acc_reg   <= '0;
                        busy_reg  <= 1'b1;
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    acc_reg <= acc_sum;
                    // Capture each date's leap flag as the sweep passes its year
                    if (cur_year == ya_reg)
                    begin
                        leap_a_reg <= cur_leap;
                    end
                    if (cur_year == yb_reg)
                    begin
                        leap_b_reg <= cur_leap;
                    end
                    if (cur_year == hi_reg)
                    begin
                        state_reg <= ST_ADD_A;
                    end
                end
                ST_ADD_A:
                begin
                    acc_reg   <= acc_sum;
                    state_reg <= ST_ADD_B;
                end
                ST_ADD_B:
                begin
                    diff_reg  <= acc_sum;
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign day_difference = diff_reg;

endmodule

// ----- hw/rtl/dd_checker.sv -----
// ----------------------------------------------------------------------------
// dd_checker: port-level checks for the date difference block
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
module dd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted request must raise busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // A result comes only at the end of a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> (!busy && $past(busy)))
        else $error("done without preceding busy period");

    // Busy drops only together with a result
    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // The strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

endmodule

bind date_difference_days dd_checker u_dd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
